[src/trt_pkg.sv]
package trt_pkg;

    localparam int unsigned MAX_FACTOR = 6;
    localparam int unsigned FACTOR_W = 3;
    localparam int unsigned WEIGHT_W = 17;
    localparam int unsigned NUM_WEIGHTS = 9;
    localparam int unsigned FRAC_BITS = 16;

    // one corner of a sub-triangle: ring level, ring side, position along it, segments
    typedef struct packed {
        logic [1:0]          level;
        logic [1:0]          side;
        logic [FACTOR_W-1:0] pos;
        logic [FACTOR_W-1:0] segs;
    } corner_t;

    // ceil(2^32 / (6*m)) for m = rings * segs; quotient by multiply is exact for our range
    localparam logic [31:0] RECIP_TAB [0:18] = '{
        32'd0,
        32'((64'd4294967296 + 64'd5) / 64'd6),
        32'((64'd4294967296 + 64'd11) / 64'd12),
        32'((64'd4294967296 + 64'd17) / 64'd18),
        32'((64'd4294967296 + 64'd23) / 64'd24),
        32'((64'd4294967296 + 64'd29) / 64'd30),
        32'((64'd4294967296 + 64'd35) / 64'd36),
        32'((64'd4294967296 + 64'd41) / 64'd42),
        32'((64'd4294967296 + 64'd47) / 64'd48),
        32'((64'd4294967296 + 64'd53) / 64'd54),
        32'((64'd4294967296 + 64'd59) / 64'd60),
        32'((64'd4294967296 + 64'd65) / 64'd66),
        32'((64'd4294967296 + 64'd71) / 64'd72),
        32'((64'd4294967296 + 64'd77) / 64'd78),
        32'((64'd4294967296 + 64'd83) / 64'd84),
        32'((64'd4294967296 + 64'd89) / 64'd90),
        32'((64'd4294967296 + 64'd95) / 64'd96),
        32'((64'd4294967296 + 64'd101) / 64'd102),
        32'((64'd4294967296 + 64'd107) / 64'd108)
    };

    function automatic logic [FACTOR_W-1:0] clamp_factor(input logic [FACTOR_W-1:0] v);
        logic [FACTOR_W-1:0] r;
        begin
            if (v == '0)
                r = FACTOR_W'(1);
            else if (v > FACTOR_W'(MAX_FACTOR))
                r = FACTOR_W'(MAX_FACTOR);
            else
                r = v;
            return r;
        end
    endfunction

    // an inner side with no segments stands for its first corner
    function automatic corner_t mk_corner(input logic [1:0] level, input logic [1:0] side,
                                          input logic [FACTOR_W-1:0] pos,
                                          input logic [FACTOR_W-1:0] segs);
        corner_t c;
        begin
            c.level = level;
            c.side  = side;
            if (segs == '0)
            begin
                c.pos  = '0;
                c.segs = FACTOR_W'(1);
            end
            else
            begin
                c.pos  = pos;
                c.segs = segs;
            end
            return c;
        end
    endfunction

endpackage

[src/triangle_ring_tessellator_core.sv]
// after the start transaction is accepted, each triangle is selected in S_TRI, then its weights are computed in S_DIV
// a request yields 1..54 triangles, produced one at a time: the next one is not selected until the last one is stored
// weights go through the single shared 24x32 reciprocal multiplier, one weight per cycle
// busy stays high until the last triangle's strobe; results cannot be stalled
// asynchronous active-low reset returns the sequencer to idle with no strobe pending
module triangle_ring_tessellator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [2:0]  edge_factor_a,
    input  logic [2:0]  edge_factor_b,
    input  logic [2:0]  edge_factor_c,
    input  logic [2:0]  inner_factor,
    output logic        busy,
    output logic        result_valid,
    output logic [16:0] corner_a_w0,
    output logic [16:0] corner_a_w1,
    output logic [16:0] corner_a_w2,
    output logic [16:0] corner_b_w0,
    output logic [16:0] corner_b_w1,
    output logic [16:0] corner_b_w2,
    output logic [16:0] corner_c_w0,
    output logic [16:0] corner_c_w1,
    output logic [16:0] corner_c_w2,
    output logic        last_triangle
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TRI  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    localparam int unsigned FW = trt_pkg::FACTOR_W;
    localparam int unsigned WW = trt_pkg::WEIGHT_W;
    localparam int unsigned NW = trt_pkg::NUM_WEIGHTS;

    logic [1:0]     state_reg, state_next;
    logic [FW-1:0]  ea_reg, eb_reg, ec_reg, fc_reg;
    logic [1:0]     rings_reg;
    logic [1:0]     r_reg, r_next;
    logic [1:0]     side_reg, side_next;
    logic [FW-1:0]  ip_reg, ip_next;
    logic [FW-1:0]  op_reg, op_next;
    logic           last_tri_reg, last_tri_next;
    trt_pkg::corner_t corner_reg [0:2];
    trt_pkg::corner_t corner_next [0:2];

    logic [3:0]     idx_reg, idx_next;
    logic [1:0]     c_reg, c_next;
    logic [1:0]     k_reg, k_next;
    logic           p_vld_reg, p_vld_next;
    logic           m_vld_reg, m_vld_next;
    logic [3:0]     p_idx_reg;
    logic [3:0]     m_idx_reg;
    logic [23:0]    num_reg;
    logic [31:0]    rc_reg;
    logic [55:0]    prod_reg;
    logic [WW-1:0]  w_reg [0:NW-1];
    logic           strobe_reg, strobe_next;
    logic           last_reg;

    // input clamping
    logic [FW-1:0]  ea_c, eb_c, ec_c, fc_c, fc_raised;
    logic           accept;

    assign ea_c = trt_pkg::clamp_factor(edge_factor_a);
    assign eb_c = trt_pkg::clamp_factor(edge_factor_b);
    assign ec_c = trt_pkg::clamp_factor(edge_factor_c);
    assign fc_c = trt_pkg::clamp_factor(inner_factor);
    assign fc_raised = ((ea_c > FW'(1) || eb_c > FW'(1) || ec_c > FW'(1)) && fc_c < FW'(2))
                       ? FW'(2) : fc_c;
    assign accept = start && !busy;

    // triangle selection
    logic [1:0]     rem;
    logic [FW-1:0]  need;
    logic           stitch_mode;
    logic           final_ring;
    logic [FW-1:0]  si, so, edge_sel;
    logic [5:0]     t0, t1, t2, t3, s_in, s_out;
    logic           adv_inner;
    logic [FW-1:0]  ip_adv, op_adv;
    logic [1:0]     r_up;

    always_comb
    begin
        rem         = rings_reg - r_reg;
        need        = {rem, 1'b0};
        stitch_mode = fc_reg >= need;
        si          = fc_reg - need;
        final_ring  = (r_reg == rings_reg - 2'd1);
        r_up        = r_reg + 2'd1;
        case (side_reg)
            2'd0:    edge_sel = ec_reg;
            2'd1:    edge_sel = ea_reg;
            default: edge_sel = eb_reg;
        endcase
        so     = final_ring ? edge_sel : si + FW'(2);
        t0     = 6'({3'b0, ip_reg} + 6'd2) * 6'({3'b0, so});
        t1     = 6'({3'b0, op_reg}) * 6'({3'b0, si} + 6'd2);
        t2     = 6'({3'b0, ip_reg} + 6'd1) * 6'({3'b0, so});
        t3     = 6'({3'b0, op_reg} + 6'd1) * 6'({3'b0, si} + 6'd2);
        s_in   = (t0 > t1) ? t0 - t1 : t1 - t0;
        s_out  = (t2 > t3) ? t2 - t3 : t3 - t2;
        ip_adv = ip_reg + FW'(1);
        op_adv = op_reg + FW'(1);
        if (op_reg == so)
            adv_inner = 1'b1;
        else if (ip_reg == si)
            adv_inner = 1'b0;
        else
            adv_inner = s_in < s_out;
    end

    // weight preparation for the corner and weight under the prep pointer
    trt_pkg::corner_t cw;
    logic [1:0]     ib;
    logic [1:0]     base;
    logic [3:0]     tq, ak, bk;
    logic [6:0]     n_val;
    logic [4:0]     m_val;
    logic [6:0]     den;
    logic [23:0]    num_val;

    always_comb
    begin
        cw      = corner_reg[c_reg];
        ib      = (cw.side == 2'd2) ? 2'd0 : cw.side + 2'd1;
        base    = rings_reg - cw.level;
        tq      = 4'(cw.level) * 4'd3;
        ak      = 4'(base) + ((k_reg == cw.side) ? tq : 4'd0);
        bk      = 4'(base) + ((k_reg == ib) ? tq : 4'd0);
        n_val   = 7'(cw.segs - cw.pos) * 7'(ak) + 7'(cw.pos) * 7'(bk);
        m_val   = 5'(rings_reg) * 5'(cw.segs);
        den     = 7'(m_val) * 7'd3;
        num_val = {n_val, 17'b0} + 24'(den);
    end

    always_comb
    begin
        state_next    = state_reg;
        r_next        = r_reg;
        side_next     = side_reg;
        ip_next       = ip_reg;
        op_next       = op_reg;
        last_tri_next = last_tri_reg;
        corner_next   = corner_reg;
        idx_next      = idx_reg;
        c_next        = c_reg;
        k_next        = k_reg;
        p_vld_next    = 1'b0;
        m_vld_next    = p_vld_reg;
        strobe_next   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_TRI;
                    r_next     = 2'd0;
                    side_next  = 2'd0;
                    ip_next    = '0;
                    op_next    = '0;
                end
            end
            S_TRI:
            begin
                state_next = S_DIV;
                idx_next   = 4'd0;
                c_next     = 2'd0;
                k_next     = 2'd0;
                if (!stitch_mode)
                begin
                    // ring too small to stitch: one triangle through its three corners
                    corner_next[0] = trt_pkg::mk_corner(r_up, 2'd0, FW'(0), FW'(1));
                    corner_next[1] = trt_pkg::mk_corner(r_up, 2'd1, FW'(0), FW'(1));
                    corner_next[2] = trt_pkg::mk_corner(r_up, 2'd2, FW'(0), FW'(1));
                    r_next         = r_up;
                    last_tri_next  = final_ring;
                end
                else
                begin
                    last_tri_next = 1'b0;
                    if (adv_inner)
                    begin
                        corner_next[0] = trt_pkg::mk_corner(r_reg, side_reg, ip_adv, si);
                        corner_next[1] = trt_pkg::mk_corner(r_reg, side_reg, ip_reg, si);
                        corner_next[2] = trt_pkg::mk_corner(r_up, side_reg, op_reg, so);
                        ip_next        = ip_adv;
                    end
                    else
                    begin
                        corner_next[0] = trt_pkg::mk_corner(r_reg, side_reg, ip_reg, si);
                        corner_next[1] = trt_pkg::mk_corner(r_up, side_reg, op_reg, so);
                        corner_next[2] = trt_pkg::mk_corner(r_up, side_reg, op_adv, so);
                        op_next        = op_adv;
                    end
                    if (ip_next == si && op_next == so)
                    begin
                        ip_next = '0;
                        op_next = '0;
                        if (side_reg == 2'd2)
                        begin
                            side_next     = 2'd0;
                            r_next        = r_up;
                            last_tri_next = final_ring;
                        end
                        else
                        begin
                            side_next = side_reg + 2'd1;
                        end
                    end
                end
            end
            S_DIV:
            begin
                if (idx_reg < 4'(NW))
                begin
                    p_vld_next = 1'b1;
                    idx_next   = idx_reg + 4'd1;
                    if (k_reg == 2'd2)
                    begin
                        k_next = 2'd0;
                        c_next = c_reg + 2'd1;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
                if (m_vld_reg && m_idx_reg == 4'(NW - 1))
                begin
                    strobe_next = 1'b1;
                    state_next  = last_tri_reg ? S_IDLE : S_TRI;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            r_reg        <= 2'd0;
            side_reg     <= 2'd0;
            ip_reg       <= '0;
            op_reg       <= '0;
            last_tri_reg <= 1'b0;
            idx_reg      <= 4'd0;
            c_reg        <= 2'd0;
            k_reg        <= 2'd0;
            p_vld_reg    <= 1'b0;
            m_vld_reg    <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            r_reg        <= r_next;
            side_reg     <= side_next;
            ip_reg       <= ip_next;
            op_reg       <= op_next;
            last_tri_reg <= last_tri_next;
            idx_reg      <= idx_next;
            c_reg        <= c_next;
            k_reg        <= k_next;
            p_vld_reg    <= p_vld_next;
            m_vld_reg    <= m_vld_next;
            strobe_reg   <= strobe_next;
        end
    end

    // datapath: prep, shared multiply, store
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ea_reg    <= ea_c;
            eb_reg    <= eb_c;
            ec_reg    <= ec_c;
            fc_reg    <= fc_raised;
            rings_reg <= 2'((4'(fc_raised) + 4'd1) >> 1);
        end
        corner_reg <= corner_next;
        if (p_vld_next)
        begin
            num_reg   <= num_val;
            rc_reg    <= trt_pkg::RECIP_TAB[m_val];
            p_idx_reg <= idx_reg;
        end
        if (p_vld_reg)
        begin
            prod_reg  <= 56'(num_reg) * 56'(rc_reg);
            m_idx_reg <= p_idx_reg;
        end
        if (m_vld_reg)
            w_reg[m_idx_reg] <= prod_reg[32 +: WW];
        if (strobe_next)
            last_reg <= last_tri_reg;
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_valid  = strobe_reg;
    assign corner_a_w0   = w_reg[0];
    assign corner_a_w1   = w_reg[1];
    assign corner_a_w2   = w_reg[2];
    assign corner_b_w0   = w_reg[3];
    assign corner_b_w1   = w_reg[4];
    assign corner_b_w2   = w_reg[5];
    assign corner_c_w0   = w_reg[6];
    assign corner_c_w1   = w_reg[7];
    assign corner_c_w2   = w_reg[8];
    assign last_triangle = last_reg;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam int DRAIN_AT    = 105;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [2:0] ea;
        logic [2:0] eb;
        logic [2:0] ec;
        logic [2:0] fc;
    } request_t;

    typedef struct {
        logic [16:0] w [0:8];
        logic        last;
    } triangle_t;

    typedef struct {
        longint unsigned n [0:2];
        longint unsigned d;
    } bpoint_t;

    logic        clk;
    logic        rst_n;
    logic        start = 1'b0;
    logic [2:0]  edge_factor_a = 3'd0;
    logic [2:0]  edge_factor_b = 3'd0;
    logic [2:0]  edge_factor_c = 3'd0;
    logic [2:0]  inner_factor = 3'd0;
    logic        busy;
    logic        result_valid;
    logic [16:0] corner_a_w0, corner_a_w1, corner_a_w2;
    logic [16:0] corner_b_w0, corner_b_w1, corner_b_w2;
    logic [16:0] corner_c_w0, corner_c_w1, corner_c_w2;
    logic        last_triangle;

    request_t  pending_reqs [$];
    triangle_t expected_tris [$];
    triangle_t req_tris [$];
    request_t  cur_req;
    int        fail_count = 0;
    int        cycle_count = 0;
    int        sent_count = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    bit        stim_done = 1'b0;
    bit        drain_done = 1'b0;
    logic      accepted_last;

    triangle_ring_tessellator_core u_dut (
        .clk(clk), .rst_n(rst_n), .start(start),
        .edge_factor_a(edge_factor_a), .edge_factor_b(edge_factor_b),
        .edge_factor_c(edge_factor_c), .inner_factor(inner_factor),
        .busy(busy), .result_valid(result_valid),
        .corner_a_w0(corner_a_w0), .corner_a_w1(corner_a_w1), .corner_a_w2(corner_a_w2),
        .corner_b_w0(corner_b_w0), .corner_b_w1(corner_b_w1), .corner_b_w2(corner_b_w2),
        .corner_c_w0(corner_c_w0), .corner_c_w1(corner_c_w1), .corner_c_w2(corner_c_w2),
        .last_triangle(last_triangle)
    );

    function automatic longint unsigned clip_factor(input logic [2:0] v);
        if (v == 3'd0)
            return 64'd1;
        if (v > 3'(trt_pkg::MAX_FACTOR))
            return 64'(trt_pkg::MAX_FACTOR);
        return {61'b0, v};
    endfunction

    function automatic bpoint_t side_point(input longint unsigned q,
                                           input longint unsigned rings,
                                           input logic [1:0] ia, input logic [1:0] ib,
                                           input longint unsigned pos,
                                           input longint unsigned segs);
        bpoint_t p;
        longint unsigned ca, cb;
        if (segs == 64'd0)
        begin
            segs = 64'd1;
            pos = 64'd0;
        end
        for (logic [1:0] k = 2'd0; k < 2'd3; k++)
        begin
            ca = (rings - q) + ((k == ia) ? 64'd3 * q : 64'd0);
            cb = (rings - q) + ((k == ib) ? 64'd3 * q : 64'd0);
            p.n[k] = (segs - pos) * ca + pos * cb;
        end
        p.d = 64'd3 * rings * segs;
        return p;
    endfunction

    function automatic logic [16:0] round_q16(input longint unsigned n,
                                              input longint unsigned d);
        longint unsigned v;
        v = (n * 64'd131072 + d) / (64'd2 * d);
        return v[16:0];
    endfunction

    function automatic void add_triangle(input bpoint_t p0, input bpoint_t p1,
                                         input bpoint_t p2);
        triangle_t t;
        for (logic [1:0] k = 2'd0; k < 2'd3; k++)
        begin
            t.w[4'(k)]         = round_q16(p0.n[k], p0.d);
            t.w[4'(k) + 4'd3]  = round_q16(p1.n[k], p1.d);
            t.w[4'(k) + 4'd6]  = round_q16(p2.n[k], p2.d);
        end
        t.last = 1'b0;
        if (req_tris.size() < 54)
            req_tris = {req_tris, t};
    endfunction

    function automatic void stitch_sides(input longint unsigned rings, input logic [1:0] ia,
                                         input logic [1:0] ib, input longint unsigned qi,
                                         input longint unsigned si, input longint unsigned qo,
                                         input longint unsigned so);
        longint unsigned ip, op, s_in, s_out, x, y;
        bit adv_inner;
        ip = 64'd0;
        op = 64'd0;
        while (ip < si || op < so)
        begin
            if (op >= so)
                adv_inner = 1'b1;
            else if (ip >= si)
                adv_inner = 1'b0;
            else
            begin
                x = (ip + 64'd2) * so;
                y = op * (si + 64'd2);
                s_in = (x > y) ? x - y : y - x;
                x = (ip + 64'd1) * so;
                y = (op + 64'd1) * (si + 64'd2);
                s_out = (x > y) ? x - y : y - x;
                adv_inner = s_in < s_out;
            end
            if (adv_inner)
            begin
                add_triangle(side_point(qi, rings, ia, ib, ip + 64'd1, si),
                             side_point(qi, rings, ia, ib, ip, si),
                             side_point(qo, rings, ia, ib, op, so));
                ip++;
            end
            else
            begin
                add_triangle(side_point(qi, rings, ia, ib, ip, si),
                             side_point(qo, rings, ia, ib, op, so),
                             side_point(qo, rings, ia, ib, op + 64'd1, so));
                op++;
            end
        end
    endfunction

    function automatic void tessellate(input request_t rq);
        longint unsigned ea, eb, ec, fc, rings, need, si;
        ea = clip_factor(rq.ea);
        eb = clip_factor(rq.eb);
        ec = clip_factor(rq.ec);
        fc = clip_factor(rq.fc);
        req_tris.delete();
        if ((ea > 64'd1 || eb > 64'd1 || ec > 64'd1) && fc < 64'd2)
            fc = 64'd2;
        rings = (fc + 64'd1) / 64'd2;
        for (longint unsigned r = 64'd0; r + 64'd1 < rings; r++)
        begin
            need = 64'd2 * (rings - r);
            if (fc >= need)
            begin
                si = fc - need;
                stitch_sides(rings, 2'd0, 2'd1, r, si, r + 64'd1, si + 64'd2);
                stitch_sides(rings, 2'd1, 2'd2, r, si, r + 64'd1, si + 64'd2);
                stitch_sides(rings, 2'd2, 2'd0, r, si, r + 64'd1, si + 64'd2);
            end
            else
                add_triangle(side_point(r + 64'd1, rings, 2'd0, 2'd1, 64'd0, 64'd1),
                             side_point(r + 64'd1, rings, 2'd1, 2'd2, 64'd0, 64'd1),
                             side_point(r + 64'd1, rings, 2'd2, 2'd0, 64'd0, 64'd1));
        end
        if (fc >= 64'd2)
        begin
            si = fc - 64'd2;
            stitch_sides(rings, 2'd0, 2'd1, rings - 64'd1, si, rings, ec);
            stitch_sides(rings, 2'd1, 2'd2, rings - 64'd1, si, rings, ea);
            stitch_sides(rings, 2'd2, 2'd0, rings - 64'd1, si, rings, eb);
        end
        else
            add_triangle(side_point(rings, rings, 2'd0, 2'd1, 64'd0, 64'd1),
                         side_point(rings, rings, 2'd1, 2'd2, 64'd0, 64'd1),
                         side_point(rings, rings, 2'd2, 2'd0, 64'd0, 64'd1));
        if (req_tris.size() > 0)
            req_tris[req_tris.size() - 1].last = 1'b1;
        expected_tris = {expected_tris, req_tris};
    endfunction

    function automatic void queue_req(input logic [2:0] ea, input logic [2:0] eb,
                                      input logic [2:0] ec, input logic [2:0] fc);
        request_t rq;
        rq.ea = ea;
        rq.eb = eb;
        rq.ec = ec;
        rq.fc = fc;
        pending_reqs = {pending_reqs, rq};
    endfunction

    task automatic rq_drive();
        cur_req = pending_reqs.pop_front();
        edge_factor_a <= cur_req.ea;
        edge_factor_b <= cur_req.eb;
        edge_factor_c <= cur_req.ec;
        inner_factor <= cur_req.fc;
        start <= 1'b1;
        sent_count++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 6);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        logic [2:0] dir_vals [0:3];
        rst_n = 1'b0;
        dir_vals = '{3'd0, 3'd1, 3'd6, 3'd7};
        // corners of the factor range, zero and out-of-range values clamped
        for (int i = 0; i < 16; i++)
            queue_req(dir_vals[2'(i)], dir_vals[2'(i / 4)], dir_vals[2'(i + i / 4)],
                      dir_vals[2'(i / 2)]);
        queue_req(3'd1, 3'd1, 3'd1, 3'd1);
        queue_req(3'd1, 3'd1, 3'd1, 3'd6);
        queue_req(3'd6, 3'd6, 3'd6, 3'd6);
        queue_req(3'd3, 3'd1, 3'd5, 3'd0);
        queue_req(3'd2, 3'd4, 3'd6, 3'd3);
        queue_req(3'd5, 3'd2, 3'd3, 3'd5);
        for (int i = 0; i < 188; i++)
            queue_req(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                      3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // driver: bursts and gaps, plus one full drain pause part way through
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || accepted_last)
        begin
            if (pending_reqs.size() == 0)
            begin
                start <= 1'b0;
                stim_done <= 1'b1;
            end
            else if (!drain_done && sent_count == DRAIN_AT)
            begin
                start <= 1'b0;
                if (expected_tris.size() == 0 && !busy)
                    drain_done <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end
            else
            begin
                rq_drive();
            end
        end
    end

    // monitor and predictor
    always @(posedge clk or negedge rst_n)
    begin
        triangle_t exp_t;
        logic [16:0] got [0:8];
        if (!rst_n)
            accepted_last <= 1'b0;
        else
        begin
            if (result_valid)
            begin
                got = '{corner_a_w0, corner_a_w1, corner_a_w2, corner_b_w0, corner_b_w1,
                        corner_b_w2, corner_c_w0, corner_c_w1, corner_c_w2};
                if (expected_tris.size() == 0)
                begin
                    $error("unexpected triangle");
                    fail_count++;
                end
                else
                begin
                    exp_t = expected_tris.pop_front();
                    for (logic [3:0] k = 4'd0; k < 4'd9; k++)
                        if (got[k] !== exp_t.w[k])
                        begin
                            $error("corner_%s_w%0d: expected %0d actual %0d",
                                   (k < 4'd3) ? "a" : (k < 4'd6) ? "b" : "c", k % 4'd3,
                                   exp_t.w[k], got[k]);
                            fail_count++;
                        end
                    if (last_triangle !== exp_t.last)
                    begin
                        $error("last_triangle: expected %0d actual %0d", exp_t.last,
                               last_triangle);
                        fail_count++;
                    end
                end
            end
            accepted_last <= start && !busy;
            if (start && !busy)
                tessellate(cur_req);
        end
    end

    initial
    begin
        wait (stim_done);
        while (expected_tris.size() != 0 || busy)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (fail_count == 0 && expected_tris.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

endmodule
